/* design/pid_position_drive_gear_clamp_unit_assert.svh */
// Assertion macros shared by the controller RTL.
// PIDGC_CHECK expects clk and rst_n in the enclosing scope, PIDGC_CHECK_RST only clk.
`ifndef PID_POSITION_DRIVE_GEAR_CLAMP_UNIT_ASSERT_SVH
`define PID_POSITION_DRIVE_GEAR_CLAMP_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define PIDGC_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pidgc: check failed");
// checked at every edge, reset included
`define PIDGC_CHECK_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pidgc: reset check failed");
`else
`define PIDGC_CHECK(lbl, prop)
`define PIDGC_CHECK_RST(lbl, prop)
`endif

`endif

/* design/pidgc_pkg.sv */
package pidgc_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int GAIN_FRAC_DEF   = 16;

  localparam int GAIN_WIDTH  = 24;
  localparam int LIMIT_WIDTH = 7;
  localparam int SUM_WIDTH   = 40;
  localparam int DRIVE_WIDTH = 8;
  // low slice of the error sum in the split ki product
  localparam int ISPLIT      = 20;

  localparam int CFG_IDX_WIDTH = 3;

  localparam int TARGET_RESET    = 360 * 5;
  localparam int KP_RESET        = 45875;
  localparam int KI_RESET        = 39;
  localparam int KD_RESET        = 491520;
  localparam int SWITCH_RESET    = 45;
  localparam int LOW_LIM_RESET   = 20;
  localparam int HIGH_LIM_RESET  = 50;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_TARGET   = 3'd0,
    REG_KP       = 3'd1,
    REG_KI       = 3'd2,
    REG_KD       = 3'd3,
    REG_SWITCH   = 3'd4,
    REG_LOW_LIM  = 3'd5,
    REG_HIGH_LIM = 3'd6
  } cfg_reg_t;

  // load strobes of the product and total stages
  typedef struct packed {
    logic prod;
    logic total;
  } stage_en_t;

endpackage

/* design/pidgc_terms.sv */
module pidgc_terms #(
  parameter int EW = pidgc_pkg::COUNT_WIDTH_DEF + 1,
  parameter int TW = pidgc_pkg::GAIN_WIDTH + pidgc_pkg::SUM_WIDTH + 3
) (
  input  logic                                  clk,
  input  pidgc_pkg::stage_en_t                  en,
  input  logic        [pidgc_pkg::GAIN_WIDTH-1:0] kp,
  input  logic        [pidgc_pkg::GAIN_WIDTH-1:0] ki,
  input  logic        [pidgc_pkg::GAIN_WIDTH-1:0] kd,
  input  logic signed [EW-1:0]                  err,
  input  logic signed [EW:0]                    diff,
  input  logic signed [pidgc_pkg::SUM_WIDTH-1:0] sum,
  output logic signed [TW-1:0]                  total_r
);

  localparam int GW  = pidgc_pkg::GAIN_WIDTH;
  localparam int SW  = pidgc_pkg::SUM_WIDTH;
  localparam int LW  = pidgc_pkg::ISPLIT;
  localparam int HW  = SW - LW;
  localparam int PW  = GW + 1 + EW;
  localparam int DW  = GW + 2 + EW;
  localparam int LOW = GW + LW;
  localparam int HIW = GW + 1 + HW;

  logic signed [PW-1:0]  p_nxt, p_r;
  logic signed [DW-1:0]  d_nxt, d_r;
  logic        [LOW-1:0] ilo_nxt, ilo_r;
  logic signed [HIW-1:0] ihi_nxt, ihi_r;
  logic signed [TW-1:0]  p_x, d_x, hi_x, lo_x, total_nxt;

  // ki * sum is taken in two halves so neither half product exceeds 25 x 20 bits
  assign p_nxt   = $signed({1'b0, kp}) * err;
  assign d_nxt   = $signed({1'b0, kd}) * diff;
  assign ilo_nxt = ki * sum[LW-1:0];
  assign ihi_nxt = $signed({1'b0, ki}) * $signed(sum[SW-1:LW]);

  always_ff @(posedge clk) begin
    if (en.prod) begin
      p_r   <= p_nxt;
      d_r   <= d_nxt;
      ilo_r <= ilo_nxt;
      ihi_r <= ihi_nxt;
    end
  end

  // exact wide sum of the registered product terms
  assign p_x       = TW'(p_r);
  assign d_x       = TW'(d_r);
  assign hi_x      = TW'(ihi_r) <<< LW;
  assign lo_x      = TW'(ilo_r);
  assign total_nxt = p_x + d_x + hi_x + lo_x;

  always_ff @(posedge clk) begin
    if (en.total) begin
      total_r <= total_nxt;
    end
  end

endmodule

/* design/pid_position_drive_gear_clamp_unit.sv */
// Channel   Dir  Fields (low bit up)              Accepted when
// in_*      in   encoder_count                    in_tvalid && in_tready
// out_*     out  drive                            out_tvalid && out_tready
// cfg_*     in   register index, write data       cfg_wen
//
// One item per cycle while the output is not stalled; after its input item is accepted the result
// passes through four register stages: error/sum state, products, wide total, clamped drive.
// The error sum recurrence closes within the entry stage.
// Reset (rst_n low at a clock edge) empties the pipeline, clears the error state
// and loads the default registers.
// A stage holds only while it is full and the stage after it holds, so an input item
// is taken while a result waits whenever a bubble remains in the pipeline.
`include "pid_position_drive_gear_clamp_unit_assert.svh"

module pid_position_drive_gear_clamp_unit #(
  parameter int COUNT_WIDTH    = pidgc_pkg::COUNT_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = pidgc_pkg::GAIN_FRAC_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [COUNT_WIDTH-1:0] encoder_count
  input  logic [((COUNT_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // [7:0] drive
  output logic [pidgc_pkg::DRIVE_WIDTH-1:0] out_tdata,
  input  logic cfg_wen,
  input  logic [pidgc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [((COUNT_WIDTH > pidgc_pkg::GAIN_WIDTH) ? COUNT_WIDTH
                 : pidgc_pkg::GAIN_WIDTH) - 1:0] cfg_wdata
);

  localparam int CW  = COUNT_WIDTH;
  localparam int EW  = CW + 1;
  localparam int GW  = pidgc_pkg::GAIN_WIDTH;
  localparam int SW  = pidgc_pkg::SUM_WIDTH;
  localparam int LMW = pidgc_pkg::LIMIT_WIDTH;
  localparam int OW  = pidgc_pkg::DRIVE_WIDTH;
  localparam int SX  = ((SW > EW + 1) ? SW : EW + 1) + 1;
  localparam int TA  = GW + SW + 3;
  localparam int TB  = GW + EW + 4;
  localparam int TW  = (TA > TB) ? TA : TB;
  localparam int QW  = TW - GAIN_FRAC_BITS;

  // configuration registers
  logic signed [CW-1:0]  target_r, switch_r;
  logic        [GW-1:0]  kp_r, ki_r, kd_r;
  logic        [LMW-1:0] low_lim_r, high_lim_r;
  pidgc_pkg::cfg_reg_t   cfg_sel;

  assign cfg_sel = pidgc_pkg::cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= CW'(pidgc_pkg::TARGET_RESET);
      kp_r       <= GW'(pidgc_pkg::KP_RESET);
      ki_r       <= GW'(pidgc_pkg::KI_RESET);
      kd_r       <= GW'(pidgc_pkg::KD_RESET);
      switch_r   <= CW'(pidgc_pkg::SWITCH_RESET);
      low_lim_r  <= LMW'(pidgc_pkg::LOW_LIM_RESET);
      high_lim_r <= LMW'(pidgc_pkg::HIGH_LIM_RESET);
    end else if (cfg_wen) begin
      case (cfg_sel)
        pidgc_pkg::REG_TARGET:   target_r   <= cfg_wdata[CW-1:0];
        pidgc_pkg::REG_KP:       kp_r       <= cfg_wdata[GW-1:0];
        pidgc_pkg::REG_KI:       ki_r       <= cfg_wdata[GW-1:0];
        pidgc_pkg::REG_KD:       kd_r       <= cfg_wdata[GW-1:0];
        pidgc_pkg::REG_SWITCH:   switch_r   <= cfg_wdata[CW-1:0];
        pidgc_pkg::REG_LOW_LIM:  low_lim_r  <= cfg_wdata[LMW-1:0];
        pidgc_pkg::REG_HIGH_LIM: high_lim_r <= cfg_wdata[LMW-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign accept    = in_tvalid && rdy1;

  // stage 1: error, trapezoid sum, gear select
  logic signed [CW-1:0] count;
  logic signed [EW-1:0] err_nxt, prev_error_r;
  logic signed [EW:0]   trap, diff_nxt, diff1_r;
  logic signed [SX-1:0] s_ext;
  logic                 sat_hi, sat_lo;
  logic signed [SW-1:0] sum_nxt, error_sum_r;
  logic [LMW-1:0]       lim_nxt, lim1_r, lim2_r, lim3_r;

  assign count    = $signed(in_tdata[CW-1:0]);
  assign err_nxt  = EW'(target_r) - EW'(count);
  assign trap     = (EW + 1)'(prev_error_r) + (EW + 1)'(err_nxt);
  assign diff_nxt = (EW + 1)'(err_nxt) - (EW + 1)'(prev_error_r);
  assign s_ext    = SX'(error_sum_r) + SX'(trap);
  assign sat_hi   = !s_ext[SX-1] && (s_ext[SX-2:SW-1] != '0);
  assign sat_lo   = s_ext[SX-1] && (s_ext[SX-2:SW-1] != '1);

  always_comb begin
    if (sat_hi) begin
      sum_nxt = {1'b0, {(SW - 1){1'b1}}};
    end else if (sat_lo) begin
      sum_nxt = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      sum_nxt = s_ext[SW-1:0];
    end
  end

  assign lim_nxt = (count < switch_r) ? low_lim_r : high_lim_r;

  // prev_error_r and error_sum_r double as the stage 1 error and sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
      error_sum_r  <= '0;
    end else if (accept) begin
      prev_error_r <= err_nxt;
      error_sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff1_r <= diff_nxt;
      lim1_r  <= lim_nxt;
    end
  end

  // stages 2 and 3: products and their total
  pidgc_pkg::stage_en_t en;
  logic signed [TW-1:0] total_r;

  assign en = '{prod: rdy2, total: rdy3};

  pidgc_terms #(
    .EW (EW),
    .TW (TW)
  ) u_terms (
    .clk     (clk),
    .en      (en),
    .kp      (kp_r),
    .ki      (ki_r),
    .kd      (kd_r),
    .err     (prev_error_r),
    .diff    (diff1_r),
    .sum     (error_sum_r),
    .total_r (total_r)
  );

  always_ff @(posedge clk) begin
    if (rdy2) begin
      lim2_r <= lim1_r;
    end
    if (rdy3) begin
      lim3_r <= lim2_r;
    end
  end

  // stage 4: scale toward zero, clamp
  logic signed [QW-1:0] q_fl, q_tz, lim_s, lim_n, q_sel;
  logic [OW-1:0]        drive_r;

  assign q_fl  = total_r[TW-1:GAIN_FRAC_BITS];
  assign q_tz  = q_fl + QW'(total_r[TW-1] && (total_r[GAIN_FRAC_BITS-1:0] != '0));
  assign lim_s = $signed(QW'(lim3_r));
  assign lim_n = -lim_s;

  always_comb begin
    if (q_tz > lim_s) begin
      q_sel = lim_s;
    end else if (q_tz < lim_n) begin
      q_sel = lim_n;
    end else begin
      q_sel = q_tz;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      drive_r <= q_sel[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = drive_r;

  `PIDGC_CHECK(a_drive_no_min, out_tvalid |-> (out_tdata != {1'b1, {(OW - 1){1'b0}}}))
  `PIDGC_CHECK(a_state_hold, !accept |=> ($stable(error_sum_r) && $stable(prev_error_r)))
  `PIDGC_CHECK(a_total_hold, (v3_r && !rdy4) |=> (v3_r && $stable(total_r)))
  `PIDGC_CHECK_RST(a_reset_empty, !rst_n |=> (!v1_r && !v2_r && !v3_r && !v4_r))

endmodule
